/* src/cau_pkg.sv */
// Shared constants, command codes and pipeline word types for the
// complex arithmetic unit. No dependencies.
package cau_pkg;

    localparam int DW   = 32;              // data width
    localparam int FB   = 16;              // fraction bits
    localparam int PW   = 2 * DW + 1;      // full-width sum of products
    localparam int QB   = DW + 1;          // quotient bits kept by the divider
    localparam int NW   = PW + FB;         // scaled numerator width
    localparam int HW   = NW - QB;         // numerator bits above the quotient window
    localparam int DENW = 2 * DW;          // squared magnitude of divisor
    localparam int CW   = (HW > DENW) ? HW : DENW;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // one result part in sign/magnitude form, with divider state
    typedef struct packed {
        logic            neg;
        logic            ovf;
        logic [PW-1:0]   mag;
        logic [DENW-1:0] rem;
        logic [QB-1:0]   numlo;
        logic [QB-1:0]   q;
    } lane_t;

    typedef struct packed {
        cmd_t            cmd;
        logic            zden;
        logic [DENW-1:0] den;
        lane_t           re;
        lane_t           im;
    } item_t;

endpackage

/* src/cau_prod.sv */
// Front end: products, sums and sign/magnitude setup, three register stages.
// Depends on cau_pkg.
module cau_prod (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_vld,
    input  logic [1:0]                   command,
    input  logic signed [cau_pkg::DW-1:0] a_real,
    input  logic signed [cau_pkg::DW-1:0] a_imag,
    input  logic signed [cau_pkg::DW-1:0] b_real,
    input  logic signed [cau_pkg::DW-1:0] b_imag,
    output logic                         out_vld,
    output cau_pkg::item_t               out_item
);
    import cau_pkg::*;

    logic                     s1_vld_reg, s2_vld_reg, s3_vld_reg;
    cmd_t                     s1_cmd_reg, s2_cmd_reg;
    logic signed [2*DW-1:0]   p1_reg, p2_reg, p3_reg, p4_reg, d1_reg, d2_reg;
    logic signed [DW:0]       sre_reg, sim_reg;
    logic signed [PW-1:0]     re_reg, im_reg, re_next, im_next;
    logic [DENW-1:0]          den_reg;
    item_t                    item_reg, item_next;
    cmd_t                     cmd_in;

    function automatic lane_t setup(input logic signed [PW-1:0] v, input cmd_t cmd,
                                    input logic [DENW-1:0] den);
        lane_t          l;
        logic [PW-1:0]  mag;
        logic [NW-1:0]  num;
        logic [CW-1:0]  hi;
        mag     = v[PW-1] ? (~v + 1'b1) : v;
        num     = NW'(mag) << FB;
        hi      = CW'(num >> QB);
        l.neg   = v[PW-1];
        l.mag   = (cmd == CMD_MUL) ? (mag >> FB) : mag;
        l.ovf   = hi >= CW'(den);
        l.rem   = DENW'(hi);
        l.numlo = num[QB-1:0];
        l.q     = '0;
        return l;
    endfunction

    assign cmd_in = cmd_t'(command);

    // stage 2 combine
    always_comb
    begin
        case (s1_cmd_reg)
            CMD_ADD:
            begin
                re_next = PW'(sre_reg);
                im_next = PW'(sim_reg);
            end
            CMD_SUB:
            begin
                re_next = PW'(sre_reg);
                im_next = PW'(sim_reg);
            end
            CMD_MUL:
            begin
                re_next = PW'(p1_reg) - PW'(p2_reg);
                im_next = PW'(p3_reg) + PW'(p4_reg);
            end
            default:
            begin
                re_next = PW'(p1_reg) + PW'(p2_reg);
                im_next = PW'(p4_reg) - PW'(p3_reg);
            end
        endcase
    end

    // stage 3 setup
    always_comb
    begin
        item_next.cmd  = s2_cmd_reg;
        item_next.den  = den_reg;
        item_next.zden = (den_reg == '0);
        item_next.re   = setup(re_reg, s2_cmd_reg, den_reg);
        item_next.im   = setup(im_reg, s2_cmd_reg, den_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg <= cmd_in;
        p1_reg     <= a_real * b_real;
        p2_reg     <= a_imag * b_imag;
        p3_reg     <= a_real * b_imag;
        p4_reg     <= a_imag * b_real;
        d1_reg     <= b_real * b_real;
        d2_reg     <= b_imag * b_imag;
        if (cmd_in == CMD_SUB)
        begin
            sre_reg <= (DW+1)'(a_real) - (DW+1)'(b_real);
            sim_reg <= (DW+1)'(a_imag) - (DW+1)'(b_imag);
        end
        else
        begin
            sre_reg <= (DW+1)'(a_real) + (DW+1)'(b_real);
            sim_reg <= (DW+1)'(a_imag) + (DW+1)'(b_imag);
        end
        s2_cmd_reg <= s1_cmd_reg;
        re_reg     <= re_next;
        im_reg     <= im_next;
        den_reg    <= DENW'(d1_reg) + DENW'(d2_reg);
        item_reg   <= item_next;
    end

    assign out_vld  = s3_vld_reg;
    assign out_item = item_reg;

endmodule

/* src/cau_div_stage.sv */
// One restoring-division step for both result parts, registered.
// Depends on cau_pkg.
module cau_div_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_vld,
    input  cau_pkg::item_t in_item,
    output logic           out_vld,
    output cau_pkg::item_t out_item
);
    import cau_pkg::*;

    logic  vld_reg;
    item_t item_reg, item_next;

    function automatic lane_t step(input lane_t l, input logic [DENW-1:0] den);
        lane_t       r;
        logic [DENW:0] t;
        logic        ge;
        r       = l;
        t       = {l.rem, l.numlo[QB-1]};
        ge      = t >= {1'b0, den};
        r.rem   = ge ? DENW'(t - {1'b0, den}) : t[DENW-1:0];
        r.numlo = l.numlo << 1;
        r.q     = {l.q[QB-2:0], ge};
        return r;
    endfunction

    always_comb
    begin
        item_next    = in_item;
        item_next.re = step(in_item.re, in_item.den);
        item_next.im = step(in_item.im, in_item.den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule

/* src/cau_div.sv */
// Divider pipeline: one quotient bit per stage, QB stages.
// Depends on cau_pkg, cau_div_stage.
module cau_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_vld,
    input  cau_pkg::item_t in_item,
    output logic           out_vld,
    output cau_pkg::item_t out_item
);
    import cau_pkg::*;

    logic  vld_chain [0:QB];
    item_t item_chain [0:QB];

    assign vld_chain[0]  = in_vld;
    assign item_chain[0] = in_item;

    for (genvar i = 0; i < QB; i++)
    begin : g_stage
        cau_div_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (vld_chain[i]),
            .in_item  (item_chain[i]),
            .out_vld  (vld_chain[i+1]),
            .out_item (item_chain[i+1])
        );
    end

    assign out_vld  = vld_chain[QB];
    assign out_item = item_chain[QB];

endmodule

/* src/complex_arithmetic_unit.sv */
// Complex add/subtract/multiply/divide on signed fixed-point operands.
// Depends on cau_pkg, cau_prod, cau_div.
//
//  channel   | ports                                      | handshake
//  ----------+--------------------------------------------+---------------------
//  input     | command, a_real, a_imag, b_real, b_imag    | start & !busy
//  result    | res_real, res_imag, status                 | done, one-cycle strobe
//
// Fully pipelined: one word accepted per cycle, busy is always low.
// Each word passes three front-end stages (products, combine,
// sign/magnitude setup), one stage per quotient bit in the divider
// chain, and the saturation output register.
// All commands ride the same chain so results leave in order.
// Reset clears only the valid bits; the receiver cannot stall.
module complex_arithmetic_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    command,
    input  logic signed [cau_pkg::DW-1:0] a_real,
    input  logic signed [cau_pkg::DW-1:0] a_imag,
    input  logic signed [cau_pkg::DW-1:0] b_real,
    input  logic signed [cau_pkg::DW-1:0] b_imag,
    output logic                          done,
    output logic signed [cau_pkg::DW-1:0] res_real,
    output logic signed [cau_pkg::DW-1:0] res_imag,
    output logic [1:0]                    status
);
    import cau_pkg::*;

    localparam logic [PW-1:0] LIM_POS = (PW'(1) << (DW - 1)) - PW'(1);
    localparam logic [PW-1:0] LIM_NEG = PW'(1) << (DW - 1);
    localparam logic [DW-1:0] MAX_V   = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MIN_V   = {1'b1, {(DW-1){1'b0}}};

    logic          fe_vld, dv_vld;
    item_t         fe_item, dv_item;
    logic          done_reg;
    logic [DW-1:0] re_reg, im_reg, re_next, im_next;
    logic [1:0]    status_reg, status_next;
    logic          re_over, im_over;

    // final signed value of one part, saturated; over flags a clamp
    function automatic logic [DW:0] finish(input lane_t l, input cmd_t cmd);
        logic [PW-1:0] mag;
        logic          over;
        logic [DW-1:0] v;
        mag  = (cmd == CMD_DIV) ? PW'(l.q) : l.mag;
        over = ((cmd == CMD_DIV) && l.ovf) || (l.neg ? (mag > LIM_NEG) : (mag > LIM_POS));
        if (over)
        begin
            v = l.neg ? MIN_V : MAX_V;
        end
        else
        begin
            v = l.neg ? (~mag[DW-1:0] + 1'b1) : mag[DW-1:0];
        end
        return {over, v};
    endfunction

    assign busy = 1'b0;

    cau_prod u_prod (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (start & ~busy),
        .command  (command),
        .a_real   (a_real),
        .a_imag   (a_imag),
        .b_real   (b_real),
        .b_imag   (b_imag),
        .out_vld  (fe_vld),
        .out_item (fe_item)
    );

    cau_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (fe_vld),
        .in_item  (fe_item),
        .out_vld  (dv_vld),
        .out_item (dv_item)
    );

    always_comb
    begin
        {re_over, re_next} = finish(dv_item.re, dv_item.cmd);
        {im_over, im_next} = finish(dv_item.im, dv_item.cmd);
        status_next = (re_over || im_over) ? ST_SAT : ST_OK;
        // divide by a zero divisor: zero result, own status
        if ((dv_item.cmd == CMD_DIV) && dv_item.zden)
        begin
            re_next     = '0;
            im_next     = '0;
            status_next = ST_DIV0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        re_reg     <= re_next;
        im_reg     <= im_next;
        status_reg <= status_next;
    end

    assign done     = done_reg;
    assign res_real = re_reg;
    assign res_imag = im_reg;
    assign status   = status_reg;

endmodule
